// ===== hw/rtl/rainbow_led_colour_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef RAINBOW_LED_COLOUR_GENERATOR_MACROS_SVH
`define RAINBOW_LED_COLOUR_GENERATOR_MACROS_SVH

// same-cycle implication
`define RLCG_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLCG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rlcg_pkg.sv =====
// ----------------------------------------------------------------------------
// rlcg_pkg
// Types and constants shared by the rainbow LED colour generator.
// ----------------------------------------------------------------------------
package rlcg_pkg;

  localparam int CNT_W   = 7;   // LED count field
  localparam int IDX_W   = 6;   // LED index field
  localparam int HUE_W   = 16;  // hue fraction of a turn
  localparam int CH_W    = 8;   // colour channel
  localparam int PER_W   = 16;  // period in ticks
  localparam int DIV_NW  = 32;  // divider numerator width
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 16;

  localparam int MQ_DEPTH = 2;  // frame queue between front and back
  localparam int OQ_DEPTH = 8;  // result queue

  localparam logic [CFG_IW-1:0] REG_LED_COUNT  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_PERIOD     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SATURATION = 3'd2;
  localparam logic [CFG_IW-1:0] REG_BRIGHTNESS = 3'd3;

  localparam logic [DIV_NW-1:0] HUE_ONE = 32'h0001_0000;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV_BASE,
    FE_DIV_STEP
  } fe_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] led_count;
    logic [PER_W-1:0] period;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  bright;
  } cfg_t;

  // one frame's worth of work for the back end
  typedef struct packed {
    logic [HUE_W-1:0] base;     // phase hue offset
    logic [HUE_W-1:0] step_q;   // 65536 / count, low 16 bits
    logic [CNT_W-1:0] step_r;   // 65536 % count
    logic [CNT_W-1:0] count;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  bright;
  } frame_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [PER_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [HUE_W-1:0] quot;
    logic [PER_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/rlcg_div.sv =====
// ----------------------------------------------------------------------------
// rlcg_div
// Restoring serial divider, one quotient bit per cycle, low 16 bits kept.
// ----------------------------------------------------------------------------
module rlcg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rlcg_pkg::div_req_t req,
  output rlcg_pkg::div_rsp_t rsp
);

  localparam int STEP_W = $clog2(rlcg_pkg::DIV_NW);

  logic                        busy_r;
  logic                        done_r;
  logic [STEP_W-1:0]           step_r;
  logic [rlcg_pkg::DIV_NW-1:0] num_r;
  logic [rlcg_pkg::PER_W-1:0]  den_r;
  logic [rlcg_pkg::PER_W-1:0]  rem_r;
  logic [rlcg_pkg::HUE_W-1:0]  quot_r;

  logic [rlcg_pkg::PER_W:0]    trial;
  logic                        ge;
  logic [rlcg_pkg::PER_W:0]    diff;

  assign trial = {rem_r, num_r[rlcg_pkg::DIV_NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == STEP_W'(rlcg_pkg::DIV_NW - 1));
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(rlcg_pkg::DIV_NW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      num_r  <= req.dividend;
      den_r  <= req.divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      num_r  <= {num_r[rlcg_pkg::DIV_NW-2:0], 1'b0};
      rem_r  <= ge ? diff[rlcg_pkg::PER_W-1:0] : trial[rlcg_pkg::PER_W-1:0];
      quot_r <= {quot_r[rlcg_pkg::HUE_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== hw/rtl/rlcg_queue.sv =====
// ----------------------------------------------------------------------------
// rlcg_queue
// Short frame queue between front and back ends.
// ----------------------------------------------------------------------------
module rlcg_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  rlcg_pkg::frame_t wr_data,
  input  logic             rd_en,
  output rlcg_pkg::frame_t rd_data,
  output logic             q_full,
  output logic             q_empty
);

  localparam int PTR_W = $clog2(rlcg_pkg::MQ_DEPTH);
  localparam int CNT_W = $clog2(rlcg_pkg::MQ_DEPTH + 1);

  rlcg_pkg::frame_t  mem_r [rlcg_pkg::MQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = cnt_r == CNT_W'(rlcg_pkg::MQ_DEPTH);
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(rlcg_pkg::MQ_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(rlcg_pkg::MQ_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/rlcg_front.sv =====
// ----------------------------------------------------------------------------
// rlcg_front
// Takes tick items, works out the frame's hue base and LED step, keeps phase.
// ----------------------------------------------------------------------------
module rlcg_front #(
  parameter int MAX_LEDS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_tick,
  input  rlcg_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               q_push,
  output rlcg_pkg::frame_t   q_data,
  output rlcg_pkg::div_req_t div_req,
  input  rlcg_pkg::div_rsp_t div_rsp
);

  rlcg_pkg::fe_state_t state_r, state_nxt;

  logic [rlcg_pkg::PER_W-1:0] phase_r;
  logic [rlcg_pkg::PER_W-1:0] period_r;
  logic [rlcg_pkg::CNT_W-1:0] count_r;
  logic [rlcg_pkg::CH_W-1:0]  sat_r;
  logic [rlcg_pkg::CH_W-1:0]  bright_r;
  logic [rlcg_pkg::HUE_W-1:0] base_r;

  logic                       accept;
  logic                       start_frame;
  logic [rlcg_pkg::CNT_W-1:0] count_clamp;
  logic [rlcg_pkg::PER_W-1:0] period_clamp;
  logic [rlcg_pkg::PER_W:0]   phase_inc;

  assign full        = (state_r != rlcg_pkg::FE_IDLE) || q_full;
  assign accept      = push && !full;
  assign start_frame = accept && in_tick;

  always_comb begin
    count_clamp = cfg.led_count;
    if (cfg.led_count == '0) begin
      count_clamp = rlcg_pkg::CNT_W'(1);
    end else if (cfg.led_count > rlcg_pkg::CNT_W'(MAX_LEDS)) begin
      count_clamp = rlcg_pkg::CNT_W'(MAX_LEDS);
    end
    period_clamp = (cfg.period == '0) ? rlcg_pkg::PER_W'(1) : cfg.period;
  end

  assign phase_inc = {1'b0, phase_r} + (rlcg_pkg::PER_W+1)'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlcg_pkg::FE_IDLE: begin
        if (start_frame) state_nxt = rlcg_pkg::FE_DIV_BASE;
      end
      rlcg_pkg::FE_DIV_BASE: begin
        if (div_rsp.done) state_nxt = rlcg_pkg::FE_DIV_STEP;
      end
      rlcg_pkg::FE_DIV_STEP: begin
        if (div_rsp.done) state_nxt = rlcg_pkg::FE_IDLE;
      end
      default: state_nxt = rlcg_pkg::FE_IDLE;
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {phase_r, {rlcg_pkg::HUE_W{1'b0}}};
    div_req.divisor  = period_clamp;
    q_push           = 1'b0;
    unique case (state_r)
      rlcg_pkg::FE_IDLE: begin
        div_req.start = start_frame;
      end
      rlcg_pkg::FE_DIV_BASE: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = rlcg_pkg::HUE_ONE;
        div_req.divisor  = {{(rlcg_pkg::PER_W-rlcg_pkg::CNT_W){1'b0}}, count_r};
      end
      rlcg_pkg::FE_DIV_STEP: begin
        q_push = div_rsp.done;
      end
      default: ;
    endcase
  end

  assign q_data.base   = base_r;
  assign q_data.step_q = div_rsp.quot;
  assign q_data.step_r = div_rsp.rem[rlcg_pkg::CNT_W-1:0];
  assign q_data.count  = count_r;
  assign q_data.sat    = sat_r;
  assign q_data.bright = bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlcg_pkg::FE_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_push) begin
        phase_r <= (phase_inc >= {1'b0, period_r}) ? '0 : phase_inc[rlcg_pkg::PER_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_frame) begin
      count_r  <= count_clamp;
      period_r <= period_clamp;
      sat_r    <= cfg.sat;
      bright_r <= cfg.bright;
    end
    if (state_r == rlcg_pkg::FE_DIV_BASE && div_rsp.done) begin
      base_r <= div_rsp.quot;
    end
  end

endmodule

// ===== hw/rtl/rlcg_back.sv =====
// ----------------------------------------------------------------------------
// rlcg_back
// Walks the LEDs of each frame, converts hue to RGB, queues the results.
// ----------------------------------------------------------------------------
`include "rainbow_led_colour_generator_macros.svh"

module rlcg_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  rlcg_pkg::frame_t           q_head,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [rlcg_pkg::IDX_W-1:0] out_led_index,
  output logic [rlcg_pkg::CH_W-1:0]  out_red,
  output logic [rlcg_pkg::CH_W-1:0]  out_green,
  output logic [rlcg_pkg::CH_W-1:0]  out_blue,
  output logic                       out_last
);

  localparam int OPTR_W = $clog2(rlcg_pkg::OQ_DEPTH);
  localparam int OCNT_W = $clog2(rlcg_pkg::OQ_DEPTH + 1);
  localparam int H6_W   = rlcg_pkg::HUE_W + 3;
  localparam int SF_W   = rlcg_pkg::HUE_W + rlcg_pkg::CH_W;

  localparam logic [2:0] SEC_RED    = 3'd0;
  localparam logic [2:0] SEC_YELLOW = 3'd1;
  localparam logic [2:0] SEC_GREEN  = 3'd2;
  localparam logic [2:0] SEC_CYAN   = 3'd3;
  localparam logic [2:0] SEC_BLUE   = 3'd4;

  localparam logic [SF_W-1:0] DEN = 24'hFF_0000;   // 255 * 65536

  typedef struct packed {
    logic [rlcg_pkg::IDX_W-1:0] idx;
    logic [rlcg_pkg::CH_W-1:0]  red;
    logic [rlcg_pkg::CH_W-1:0]  green;
    logic [rlcg_pkg::CH_W-1:0]  blue;
    logic                       last;
  } res_t;

  // floor(n / 255) from an estimate that is exact or one low
  function automatic logic [rlcg_pkg::CH_W-1:0] div255_fix(
    input logic [15:0] n,
    input logic [rlcg_pkg::CH_W-1:0] q
  );
    logic [15:0] r;
    r = n - ({q, 8'h00} - {8'h00, q});
    return (r >= 16'd255) ? q + rlcg_pkg::CH_W'(1) : q;
  endfunction

  // ---------------- LED sequencer ----------------
  logic [rlcg_pkg::IDX_W-1:0] idx_r;
  logic [rlcg_pkg::HUE_W-1:0] off_r;
  logic [rlcg_pkg::CNT_W-1:0] rem_r;
  logic [OCNT_W-1:0]          used_r;    // issued but not yet popped

  logic                       issue;
  logic                       last_led;
  logic [rlcg_pkg::CNT_W-1:0] rsum;
  logic                       wrap;
  logic [rlcg_pkg::HUE_W-1:0] hue;
  logic [H6_W-1:0]            h6;
  logic                       pop_ok;

  assign issue    = !q_empty && (used_r < OCNT_W'(rlcg_pkg::OQ_DEPTH));
  assign last_led = ({1'b0, idx_r} + rlcg_pkg::CNT_W'(1)) == q_head.count;
  assign q_pop    = issue && last_led;
  assign rsum     = rem_r + q_head.step_r;
  assign wrap     = rsum >= q_head.count;
  assign hue      = q_head.base + off_r;
  assign h6       = {3'b000, hue} * H6_W'(6);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      off_r  <= '0;
      rem_r  <= '0;
      used_r <= '0;
    end else begin
      used_r <= used_r + OCNT_W'(issue) - OCNT_W'(pop_ok);
      if (issue) begin
        if (last_led) begin
          idx_r <= '0;
          off_r <= '0;
          rem_r <= '0;
        end else begin
          idx_r <= idx_r + rlcg_pkg::IDX_W'(1);
          rem_r <= wrap ? rsum - q_head.count : rsum;
          off_r <= off_r + q_head.step_q + rlcg_pkg::HUE_W'(wrap);
        end
      end
    end
  end

  // ---------------- colour pipeline ----------------
  logic a_v_r, b_v_r, c_v_r, d_v_r;

  logic [2:0]                 a_sec_r, b_sec_r, c_sec_r, d_sec_r;
  logic [rlcg_pkg::IDX_W-1:0] a_idx_r, b_idx_r, c_idx_r, d_idx_r;
  logic                       a_last_r, b_last_r, c_last_r, d_last_r;
  logic [rlcg_pkg::CH_W-1:0]  a_sat_r, b_sat_r;
  logic [rlcg_pkg::CH_W-1:0]  a_bri_r, b_bri_r, c_bri_r, d_bri_r;
  logic [rlcg_pkg::HUE_W-1:0] a_frac_r;
  logic [SF_W-1:0]            b_sf_r;
  logic [15:0]                b_pn_r, c_pn_r, d_pn_r;
  logic [15:0]                c_qn_r, c_tn_r, d_qn_r, d_tn_r;
  logic [rlcg_pkg::CH_W-1:0]  d_pe_r, d_qe_r, d_te_r;

  logic [SF_W-1:0] qx, tx;
  logic [31:0]     prod_q, prod_t;
  logic [23:0]     est_p, est_q, est_t;

  assign qx     = DEN - b_sf_r;
  assign tx     = {rlcg_pkg::CH_W'(8'hFF - b_sat_r), {rlcg_pkg::HUE_W{1'b0}}} + b_sf_r;
  assign prod_q = {24'h0, b_bri_r} * {8'h0, qx};
  assign prod_t = {24'h0, b_bri_r} * {8'h0, tx};
  assign est_p  = {8'h0, c_pn_r} * 24'd257;
  assign est_q  = {8'h0, c_qn_r} * 24'd257;
  assign est_t  = {8'h0, c_tn_r} * 24'd257;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      a_v_r <= issue;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    // hue to sector and fraction
    a_sec_r  <= h6[H6_W-1:rlcg_pkg::HUE_W];
    a_frac_r <= h6[rlcg_pkg::HUE_W-1:0];
    a_idx_r  <= idx_r;
    a_last_r <= last_led;
    a_sat_r  <= q_head.sat;
    a_bri_r  <= q_head.bright;
    // s * frac, v * (255 - s)
    b_sf_r   <= {8'h0, a_sat_r} * {8'h0, a_frac_r};
    b_pn_r   <= {8'h0, a_bri_r} * {8'h0, rlcg_pkg::CH_W'(8'hFF - a_sat_r)};
    b_sec_r  <= a_sec_r;
    b_idx_r  <= a_idx_r;
    b_last_r <= a_last_r;
    b_sat_r  <= a_sat_r;
    b_bri_r  <= a_bri_r;
    // v * (den - ...), scaled down by 65536
    c_qn_r   <= prod_q[31:16];
    c_tn_r   <= prod_t[31:16];
    c_pn_r   <= b_pn_r;
    c_sec_r  <= b_sec_r;
    c_idx_r  <= b_idx_r;
    c_last_r <= b_last_r;
    c_bri_r  <= b_bri_r;
    // reciprocal estimate of n / 255
    d_pe_r   <= est_p[23:16];
    d_qe_r   <= est_q[23:16];
    d_te_r   <= est_t[23:16];
    d_pn_r   <= c_pn_r;
    d_qn_r   <= c_qn_r;
    d_tn_r   <= c_tn_r;
    d_sec_r  <= c_sec_r;
    d_idx_r  <= c_idx_r;
    d_last_r <= c_last_r;
    d_bri_r  <= c_bri_r;
  end

  logic [rlcg_pkg::CH_W-1:0] tp, tq, tt, tv;
  res_t                      res;

  always_comb begin
    tp = div255_fix(d_pn_r, d_pe_r);
    tq = div255_fix(d_qn_r, d_qe_r);
    tt = div255_fix(d_tn_r, d_te_r);
    tv = d_bri_r;
    res.idx  = d_idx_r;
    res.last = d_last_r;
    case (d_sec_r)
      SEC_RED:    begin res.red = tv; res.green = tt; res.blue = tp; end
      SEC_YELLOW: begin res.red = tq; res.green = tv; res.blue = tp; end
      SEC_GREEN:  begin res.red = tp; res.green = tv; res.blue = tt; end
      SEC_CYAN:   begin res.red = tp; res.green = tq; res.blue = tv; end
      SEC_BLUE:   begin res.red = tt; res.green = tp; res.blue = tv; end
      default:    begin res.red = tv; res.green = tp; res.blue = tq; end
    endcase
  end

  // ---------------- result queue ----------------
  res_t               oq_r [rlcg_pkg::OQ_DEPTH];
  logic [OPTR_W-1:0]  owr_r;
  logic [OPTR_W-1:0]  ord_r;
  logic [OCNT_W-1:0]  oq_cnt_r;
  res_t               head;

  assign empty  = oq_cnt_r == '0;
  assign pop_ok = pop && !empty;
  assign head   = oq_r[ord_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r    <= '0;
      ord_r    <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (d_v_r) owr_r <= owr_r + OPTR_W'(1);
      if (pop_ok) ord_r <= ord_r + OPTR_W'(1);
      oq_cnt_r <= oq_cnt_r + OCNT_W'(d_v_r) - OCNT_W'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (d_v_r) begin
      oq_r[owr_r] <= res;
    end
  end

  assign out_led_index = head.idx;
  assign out_red       = head.red;
  assign out_green     = head.green;
  assign out_blue      = head.blue;
  assign out_last      = head.last;

  `RLCG_ASSERT(a_used_bound, 1'b1, used_r <= OCNT_W'(rlcg_pkg::OQ_DEPTH), "credit count overrun")
  `RLCG_ASSERT(a_cnt_le_used, 1'b1, oq_cnt_r <= used_r, "queued results exceed credits")
  `RLCG_ASSERT(a_no_overflow, d_v_r, (oq_cnt_r < OCNT_W'(rlcg_pkg::OQ_DEPTH)) || pop_ok, "result queue overflow")
  `RLCG_ASSERT_NXT(a_frame_wrap, issue && last_led, idx_r == '0 && off_r == '0, "frame did not restart at LED zero")

endmodule

// ===== hw/rtl/rainbow_led_colour_generator.sv =====
// ----------------------------------------------------------------------------
// rainbow_led_colour_generator
// Rainbow pattern source: one RGB colour per LED for every frame tick.
// ----------------------------------------------------------------------------
// Push a tick item with in_tick=1 and the block emits led_count result items
// (0 taken as 1, capped at MAX_LEDS), LED 0 first, the final one flagged by
// out_last; a tick item with in_tick=0 is taken and dropped. Per tick the front
// end runs two serial divisions after the accept cycle, each giving quotient
// bits and then a done strobe: the phase hue base, then the per-LED hue step;
// the frame is queued in the second's done cycle. The back end emits one LED per
// cycle while the result queue has room, through the colour pipeline registers.
// Two frames can wait between the halves, so ticks are taken while results keep
// flowing; no new tick is taken until the last one is queued. Results sit in an
// 8-deep queue: the block keeps working as long as pop keeps up. Configuration
// writes (led_count, period_ticks, saturation, brightness) take effect at the
// next tick and are meant for idle periods. No clearing pass after reset.
// ----------------------------------------------------------------------------
module rainbow_led_colour_generator #(
  parameter int MAX_LEDS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // tick items
  input  logic                        push,
  output logic                        full,
  input  logic                        in_tick,
  // colour results
  output logic                        empty,
  input  logic                        pop,
  output logic [rlcg_pkg::IDX_W-1:0]  out_led_index,
  output logic [rlcg_pkg::CH_W-1:0]   out_red,
  output logic [rlcg_pkg::CH_W-1:0]   out_green,
  output logic [rlcg_pkg::CH_W-1:0]   out_blue,
  output logic                        out_last,
  // configuration writes
  input  logic                        cfg_we,
  input  logic [rlcg_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rlcg_pkg::CFG_DW-1:0] cfg_data
);

  // config registers, reset to a two-LED, 100-tick, full-colour rainbow
  rlcg_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_count <= rlcg_pkg::CNT_W'(2);
      cfg_r.period    <= rlcg_pkg::PER_W'(100);
      cfg_r.sat       <= rlcg_pkg::CH_W'(255);
      cfg_r.bright    <= rlcg_pkg::CH_W'(255);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlcg_pkg::REG_LED_COUNT:  cfg_r.led_count <= cfg_data[rlcg_pkg::CNT_W-1:0];
        rlcg_pkg::REG_PERIOD:     cfg_r.period    <= cfg_data[rlcg_pkg::PER_W-1:0];
        rlcg_pkg::REG_SATURATION: cfg_r.sat       <= cfg_data[rlcg_pkg::CH_W-1:0];
        rlcg_pkg::REG_BRIGHTNESS: cfg_r.bright    <= cfg_data[rlcg_pkg::CH_W-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // front end <-> shared divider
  rlcg_pkg::div_req_t div_req;
  rlcg_pkg::div_rsp_t div_rsp;

  // front end -> frame queue -> back end
  logic             fq_push;
  rlcg_pkg::frame_t fq_wdata;
  logic             fq_full;
  logic             fq_empty;
  logic             fq_pop;
  rlcg_pkg::frame_t fq_head;

  rlcg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rlcg_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_tick (in_tick),
    .cfg     (cfg_r),
    .q_full  (fq_full),
    .q_push  (fq_push),
    .q_data  (fq_wdata),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  rlcg_queue u_fq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_wdata),
    .rd_en   (fq_pop),
    .rd_data (fq_head),
    .q_full  (fq_full),
    .q_empty (fq_empty)
  );

  // back end: LED walk, HSV to RGB, result queue
  rlcg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (fq_empty),
    .q_head        (fq_head),
    .q_pop         (fq_pop),
    .empty         (empty),
    .pop           (pop),
    .out_led_index (out_led_index),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_last      (out_last)
  );

endmodule

// ===== tb/tb_rainbow_led_colour_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rainbow_led_colour_generator
// Self-checking bench for the rainbow LED colour generator. Tick items go in
// through the push/full side. Every LED colour that pops out is compared with
// a bench-side HSV model of the hue spread or a colour typed in the plan.
// The run starts with a short directed plan, then moves to randomized
// phases, with gaps and stalls on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_rainbow_led_colour_generator;

  localparam int          MAX_LEDS        = 64;
  localparam int          RESET_CYCLES    = 7;
  localparam int          QUIET_CYCLES    = 200;    // > one tick through both halves
  localparam int          LONG_HOLD       = 1000;   // receiver hold-off, in cycles
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int          PHASES          = 8;
  localparam int          TICKS_PER_PHASE = 10;
  localparam int          PLAN_ROWS       = 25;

  // register index with no register behind it; writes must be dropped
  localparam logic [rlcg_pkg::CFG_IW-1:0] REG_NONE = 3'd7;

  localparam longint unsigned TURN   = 65536;        // one full hue turn
  localparam longint unsigned CH_DEN = 255 * 65536;  // Q/T term denominator

  typedef struct packed {
    logic [rlcg_pkg::IDX_W-1:0] led;
    logic [rlcg_pkg::CH_W-1:0]  red;
    logic [rlcg_pkg::CH_W-1:0]  green;
    logic [rlcg_pkg::CH_W-1:0]  blue;
    logic                       last;
  } led_colour_t;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  // One row of the directed plan. For ticks, 'typed' means LED 0's colour is
  // spelled out below instead of taken from the model.
  typedef struct packed {
    row_kind_t                   kind;
    logic [rlcg_pkg::CFG_IW-1:0] idx;
    logic [rlcg_pkg::CFG_DW-1:0] data;
    logic                        tick;
    bit                          typed;
    logic [rlcg_pkg::CH_W-1:0]   red;
    logic [rlcg_pkg::CH_W-1:0]   green;
    logic [rlcg_pkg::CH_W-1:0]   blue;
  } row_t;

  // Directed plan. Phase bookkeeping: six real ticks precede the period=4 row,
  // so the tick right after it runs with the phase beyond the period.
  row_t plan [PLAN_ROWS] = '{
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b1, 8'd255, 8'd0, 8'd0}, // reset: red
    '{ROW_TICK, REG_NONE, 16'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, // dropped
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE, rlcg_pkg::REG_SATURATION, 16'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255}, // white
    '{ROW_WRITE, rlcg_pkg::REG_BRIGHTNESS, 16'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0}, // black
    '{ROW_WRITE, rlcg_pkg::REG_SATURATION, 16'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE, rlcg_pkg::REG_BRIGHTNESS, 16'd255, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE, rlcg_pkg::REG_LED_COUNT, 16'd64, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0}, // full strip
    '{ROW_TICK, REG_NONE, 16'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE, rlcg_pkg::REG_LED_COUNT, 16'd127, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, // clamps
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE, rlcg_pkg::REG_LED_COUNT, 16'd3, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE, rlcg_pkg::REG_PERIOD, 16'd4, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0}, // phase 6 of 4
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE, rlcg_pkg::REG_LED_COUNT, 16'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, // as 1
    '{ROW_WRITE, rlcg_pkg::REG_PERIOD, 16'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, // as 1
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_WRITE, REG_NONE, 16'hFFFF, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0}, // ignored
    '{ROW_WRITE, rlcg_pkg::REG_PERIOD, 16'hFFFF, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
    '{ROW_TICK, REG_NONE, 16'd0, 1'b1, 1'b1, 8'd255, 8'd0, 8'd0}  // one red LED
  };

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              push;
  logic                              full;
  logic                              in_tick;
  logic                              empty;
  logic                              pop;
  logic [rlcg_pkg::IDX_W-1:0]        out_led_index;
  logic [rlcg_pkg::CH_W-1:0]         out_red;
  logic [rlcg_pkg::CH_W-1:0]         out_green;
  logic [rlcg_pkg::CH_W-1:0]         out_blue;
  logic                              out_last;
  logic                              cfg_we;
  logic [rlcg_pkg::CFG_IW-1:0]       cfg_index;
  logic [rlcg_pkg::CFG_DW-1:0]       cfg_data;

  // Bench copy of the register file and the frame phase
  logic [rlcg_pkg::CNT_W-1:0]        leds_r;
  logic [rlcg_pkg::PER_W-1:0]        period_r;
  logic [rlcg_pkg::CH_W-1:0]         sat_r;
  logic [rlcg_pkg::CH_W-1:0]         bright_r;
  logic [rlcg_pkg::PER_W-1:0]        phase_r;

  led_colour_t         colour_q [$];         // LED colours still owed by the block
  int unsigned         mismatches  = 0;
  int unsigned         cycle_count = 0;
  bit                  in_steady      = 1'b0;  // sender runs without gaps
  bit                  long_hold_go   = 1'b0;  // ask the receiver for its long hold
  bit                  long_hold_done = 1'b0;

  rainbow_led_colour_generator #(
    .MAX_LEDS(MAX_LEDS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_tick      (in_tick),
    .empty        (empty),
    .pop          (pop),
    .out_led_index(out_led_index),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Six-sector HSV to RGB on a 16-bit hue, exact integer arithmetic.
  function automatic led_colour_t hsv_to_rgb(input logic [rlcg_pkg::HUE_W-1:0] hue,
                                             input logic [rlcg_pkg::CH_W-1:0] sat,
                                             input logic [rlcg_pkg::CH_W-1:0] val);
    logic [18:0]       h6;
    longint unsigned   frac, sl, vl, p_term, q_term, t_term;
    led_colour_t       px;
    h6     = 19'(hue) * 19'd6;
    frac   = 64'(h6[15:0]);
    sl     = 64'(sat);
    vl     = 64'(val);
    p_term = vl * (255 - sl) / 255;
    q_term = vl * (CH_DEN - sl * frac) / CH_DEN;
    t_term = vl * (CH_DEN - sl * (TURN - frac)) / CH_DEN;
    px     = '0;
    case (h6[18:16])
      3'd0: begin
        px.red = rlcg_pkg::CH_W'(vl); px.green = rlcg_pkg::CH_W'(t_term);
        px.blue = rlcg_pkg::CH_W'(p_term);
      end
      3'd1: begin
        px.red = rlcg_pkg::CH_W'(q_term); px.green = rlcg_pkg::CH_W'(vl);
        px.blue = rlcg_pkg::CH_W'(p_term);
      end
      3'd2: begin
        px.red = rlcg_pkg::CH_W'(p_term); px.green = rlcg_pkg::CH_W'(vl);
        px.blue = rlcg_pkg::CH_W'(t_term);
      end
      3'd3: begin
        px.red = rlcg_pkg::CH_W'(p_term); px.green = rlcg_pkg::CH_W'(q_term);
        px.blue = rlcg_pkg::CH_W'(vl);
      end
      3'd4: begin
        px.red = rlcg_pkg::CH_W'(t_term); px.green = rlcg_pkg::CH_W'(p_term);
        px.blue = rlcg_pkg::CH_W'(vl);
      end
      default: begin
        px.red = rlcg_pkg::CH_W'(vl); px.green = rlcg_pkg::CH_W'(p_term);
        px.blue = rlcg_pkg::CH_W'(q_term);
      end
    endcase
    return px;
  endfunction

  // Queue the colours of one frame and step the phase. A typed colour for
  // LED 0 replaces the computed one.
  task automatic predict_frame(input bit typed, input logic [rlcg_pkg::CH_W-1:0] r,
                               input logic [rlcg_pkg::CH_W-1:0] g,
                               input logic [rlcg_pkg::CH_W-1:0] b);
    int unsigned       cnt, per, nxt;
    longint unsigned   base, off;
    led_colour_t       px;
    cnt  = (leds_r == '0) ? 1 : (leds_r > MAX_LEDS) ? MAX_LEDS : 32'(leds_r);
    per  = (period_r == '0) ? 1 : 32'(period_r);
    base = 64'(phase_r);
    base = base * TURN / per;   // may exceed a turn when phase >= period
    for (int unsigned i = 0; i < cnt; i++) begin
      off      = 64'(i);
      off      = off * TURN / cnt;
      px       = hsv_to_rgb(rlcg_pkg::HUE_W'(base + off), sat_r, bright_r);
      px.led   = rlcg_pkg::IDX_W'(i);
      px.last  = (i == cnt - 1);
      if (typed && i == 0) begin
        px.red   = r;
        px.green = g;
        px.blue  = b;
      end
      colour_q = {colour_q, px};
    end
    nxt     = 32'(phase_r) + 1;
    phase_r = (nxt >= per) ? '0 : rlcg_pkg::PER_W'(nxt);
  endtask

  // Mostly back-to-back, some short gaps, rarely a long one.
  function automatic int unsigned draw_gap(input bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(15, 0);
    if (roll < 9) return 0;
    if (roll < 15) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Offer one tick item and hold it until taken. push stays up when the next
  // item follows without a gap, so it never gets two updates in one step.
  task automatic send_tick(input logic t, input bit more, input bit typed,
                           input logic [rlcg_pkg::CH_W-1:0] r,
                           input logic [rlcg_pkg::CH_W-1:0] g,
                           input logic [rlcg_pkg::CH_W-1:0] b);
    int unsigned gap;
    push    <= 1'b1;
    in_tick <= t;
    @(posedge clk);
    while (full) @(posedge clk);
    if (t) predict_frame(typed, r, g, b);
    gap = more ? draw_gap(in_steady) : 0;
    if (!more || gap != 0) push <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rlcg_pkg::CFG_IW-1:0] idx,
                           input logic [rlcg_pkg::CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      rlcg_pkg::REG_LED_COUNT:  leds_r   = data[rlcg_pkg::CNT_W-1:0];
      rlcg_pkg::REG_PERIOD:     period_r = data[rlcg_pkg::PER_W-1:0];
      rlcg_pkg::REG_SATURATION: sat_r    = data[rlcg_pkg::CH_W-1:0];
      rlcg_pkg::REG_BRIGHTNESS: bright_r = data[rlcg_pkg::CH_W-1:0];
      default: ;
    endcase
  endtask

  // All colours out, then a quiet stretch so nothing is left in flight.
  task automatic wait_idle();
    while (colour_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Result side: random pop gaps, with steady stretches toggled now and then,
  // and one long hold on request so the block backs up into full.
  initial begin : colour_sink
    int unsigned gap;
    bit          steady;
    steady = 1'b0;
    pop    <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_go && !long_hold_done) begin
        gap            = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        if ($urandom_range(39, 0) == 0) steady = !steady;
        gap = draw_gap(steady);
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Checker. Everything is read at the edge, before any of this edge's
  // updates land, so inputs and outputs are the pre-edge values.
  always @(posedge clk) begin : colour_check
    led_colour_t got, want;
    if (rst_n && pop && !empty) begin
      got = {out_led_index, out_red, out_green, out_blue, out_last};
      if (colour_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected LED item: idx=%0d rgb=%02h/%02h/%02h last=%0b",
                   got.led, got.red, got.green, got.blue, got.last);
      end else begin
        want = colour_q.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display({"LED mismatch: exp idx=%0d rgb=%02h/%02h/%02h last=%0b, ",
                      "got idx=%0d rgb=%02h/%02h/%02h last=%0b"},
                     want.led, want.red, want.green, want.blue, want.last,
                     got.led, got.red, got.green, got.blue, got.last);
        end
      end
    end
  end

  initial begin : stimulus
    logic [rlcg_pkg::CFG_DW-1:0] leds_v, per_v, sat_v, bri_v;
    int unsigned                 sent;
    logic                        t;
    rst_n     <= 1'b0;
    push      <= 1'b0;
    in_tick   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= rlcg_pkg::REG_LED_COUNT;
    cfg_data  <= '0;
    // register file after reset
    leds_r    = 7'd2;
    period_r  = 16'd100;
    sat_r     = 8'd255;
    bright_r  = 8'd255;
    phase_r   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan: writes only with the block drained
    for (int k = 0; k < PLAN_ROWS; k++) begin
      if (plan[k].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        send_tick(plan[k].tick,
                  (k + 1 < PLAN_ROWS) && (plan[k + 1].kind == ROW_TICK),
                  plan[k].typed, plan[k].red, plan[k].green, plan[k].blue);
      end
    end

    // Random phases. Phase 0 is the full strip with the long result hold,
    // phases 1 and 2 pin other register extremes (phase 2 only count and
    // period), the rest are random with junk in the unused write-data bits.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          leds_v = 16'(MAX_LEDS); per_v = 16'hFFFF; sat_v = 16'd255; bri_v = 16'd255;
        end
        1: begin
          leds_v = 16'd1; per_v = 16'd1; sat_v = 16'd0; bri_v = 16'd0;
        end
        2: begin
          leds_v = 16'd127; per_v = 16'd0;
          sat_v  = 16'($urandom); bri_v = 16'($urandom);
        end
        default: begin
          leds_v = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(127, 0))
                                               : 16'($urandom_range(8, 1));
          leds_v[15:7] = 9'($urandom);
          per_v  = ($urandom_range(1, 0) == 0) ? 16'($urandom_range(7, 0))
                                               : 16'($urandom);
          sat_v  = 16'($urandom);
          bri_v  = 16'($urandom);
        end
      endcase
      write_reg(rlcg_pkg::REG_LED_COUNT, leds_v);
      write_reg(rlcg_pkg::REG_PERIOD, per_v);
      write_reg(rlcg_pkg::REG_SATURATION, sat_v);
      write_reg(rlcg_pkg::REG_BRIGHTNESS, bri_v);
      in_steady    = (p == 0) || ($urandom_range(3, 0) == 0);
      long_hold_go = (p == 0);
      sent = 0;
      while (sent < TICKS_PER_PHASE) begin
        t = ($urandom_range(6, 0) != 0);   // about one in seven is a dropped tick
        if (t) sent++;
        send_tick(t, sent < TICKS_PER_PHASE, 1'b0, '0, '0, '0);
      end
    end

    // Drain, then watch a while for anything extra
    while (colour_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (mismatches == 0 && colour_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
